/* rtl/tkn_pkg.sv */
// tkn_pkg: shared constants for the top-k neighbor list
// no dependencies; imported by tkn_ctrl and top_k_neighbor_list
package tkn_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int INDEX_BITS_DEF = 16;
  localparam int DIST_BITS_DEF  = 32;

  // width of the keep limit register
  localparam int KEEP_W = 5;

  // command codes on in_cmd
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

endpackage

/* rtl/tkn_slot_ram.sv */
// tkn_slot_ram: one write, one read port memory holding the neighbor slots
// no package dependency; instantiated by top_k_neighbor_list
module tkn_slot_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int WORD_W = 49
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [0:DEPTH-1];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/tkn_ctrl.sv */
// tkn_ctrl: sequencer and shared compare unit for offers and drains
// depends on tkn_pkg; drives the ports of tkn_slot_ram
module tkn_ctrl #(
  parameter int CAPACITY   = tkn_pkg::CAPACITY_DEF,
  parameter int INDEX_BITS = tkn_pkg::INDEX_BITS_DEF,
  parameter int DIST_BITS  = tkn_pkg::DIST_BITS_DEF,
  parameter int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CNT_W      = $clog2(CAPACITY + 1),
  parameter int WORD_W     = 1 + INDEX_BITS + DIST_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [INDEX_BITS-1:0] in_candidate_index,
  input  logic [DIST_BITS-1:0]  in_candidate_dist,
  input  logic [CNT_W-1:0]      limit,
  output logic                  out_valid,
  output logic                  out_accepted,
  output logic                  out_entry_valid,
  output logic [INDEX_BITS-1:0] out_entry_index,
  output logic [DIST_BITS-1:0]  out_entry_dist,
  output logic                  out_entry_was_new,
  output logic                  out_last,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output logic [WORD_W-1:0]     wr_data,
  output logic [ADDR_W-1:0]     rd_addr,
  input  logic [WORD_W-1:0]     rd_data
);
  import tkn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  hit_r, hit_nxt;
  logic                  pend_r, pend_nxt;
  logic [ADDR_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic [INDEX_BITS-1:0] cand_idx_r, cand_idx_nxt;
  logic [DIST_BITS-1:0]  cand_dist_r, cand_dist_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_acc_r, out_acc_nxt;
  logic                  out_ev_r, out_ev_nxt;
  logic [INDEX_BITS-1:0] out_idx_r, out_idx_nxt;
  logic [DIST_BITS-1:0]  out_dist_r, out_dist_nxt;
  logic                  out_new_r, out_new_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [DIST_BITS-1:0]  rd_dist;
  logic [INDEX_BITS-1:0] rd_idx;
  logic                  rd_new;
  logic [CNT_W-1:0]      cnt_dec;
  logic [CNT_W-1:0]      shift_top;
  logic [CNT_W-1:0]      fill_dec;
  logic                  reject;
  logic                  drain_last;

  assign rd_dist = rd_data[DIST_BITS-1:0];
  assign rd_idx  = rd_data[DIST_BITS +: INDEX_BITS];
  assign rd_new  = rd_data[WORD_W-1];

  assign cnt_dec    = cnt_r - CNT_W'(1);
  assign fill_dec   = fill_r - CNT_W'(1);
  // a full array drops its farthest entry on insert
  assign shift_top  = (fill_r < CNT_W'(CAPACITY)) ? fill_r : CNT_W'(CAPACITY - 1);
  assign reject     = hit_r || (pos_r >= limit);
  assign drain_last = (CNT_W'(pend_addr_r) == fill_dec);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    cand_idx_nxt  = cand_idx_r;
    cand_dist_nxt = cand_dist_r;

    out_valid_nxt = 1'b0;
    out_acc_nxt   = out_acc_r;
    out_ev_nxt    = out_ev_r;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;
    out_new_nxt   = out_new_r;
    out_last_nxt  = out_last_r;

    wr_en   = 1'b0;
    wr_addr = pend_addr_r;
    wr_data = rd_data;
    rd_addr = cnt_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          if (in_cmd == CMD_DRAIN) begin
            if (fill_r == '0) begin
              // empty list: one blank word closes the drain
              out_valid_nxt = 1'b1;
              out_acc_nxt   = 1'b0;
              out_ev_nxt    = 1'b0;
              out_idx_nxt   = '0;
              out_dist_nxt  = '0;
              out_new_nxt   = 1'b0;
              out_last_nxt  = 1'b1;
            end else begin
              state_nxt = ST_DRAIN;
            end
          end else begin
            cand_idx_nxt  = in_candidate_index;
            cand_dist_nxt = in_candidate_dist;
            pos_nxt       = '0;
            hit_nxt       = 1'b0;
            state_nxt     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (pend_r) begin
          if (rd_idx == cand_idx_r || rd_dist == cand_dist_r) begin
            hit_nxt = 1'b1;
          end
          // list is sorted, so the count of closer entries is the insert slot
          if (rd_dist < cand_dist_r) begin
            pos_nxt = pos_r + CNT_W'(1);
          end
        end
        if (cnt_r < fill_r) begin
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end else if (!pend_r) begin
          if (reject) begin
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b0;
            out_ev_nxt    = 1'b0;
            out_idx_nxt   = '0;
            out_dist_nxt  = '0;
            out_new_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cnt_nxt   = shift_top;
            state_nxt = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          wr_data = rd_data;
        end
        if (cnt_r > pos_r) begin
          // move slot cnt-1 up to slot cnt
          rd_addr       = cnt_dec[ADDR_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r[ADDR_W-1:0];
          cnt_nxt       = cnt_dec;
        end else if (!pend_r) begin
          wr_en         = 1'b1;
          wr_addr       = pos_r[ADDR_W-1:0];
          wr_data       = {1'b1, cand_idx_r, cand_dist_r};
          fill_nxt      = (fill_r >= limit) ? limit : fill_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b1;
          out_ev_nxt    = 1'b0;
          out_idx_nxt   = '0;
          out_dist_nxt  = '0;
          out_new_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        if (cnt_r < fill_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r[ADDR_W-1:0];
          cnt_nxt       = cnt_r + CNT_W'(1);
        end
        if (pend_r) begin
          // emit the word and write it back with the new flag cleared
          wr_en         = 1'b1;
          wr_addr       = pend_addr_r;
          wr_data       = {1'b0, rd_idx, rd_dist};
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b0;
          out_ev_nxt    = 1'b1;
          out_idx_nxt   = rd_idx;
          out_dist_nxt  = rd_dist;
          out_new_nxt   = rd_new;
          out_last_nxt  = drain_last;
          if (drain_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    pos_r       <= pos_nxt;
    hit_r       <= hit_nxt;
    pend_addr_r <= pend_addr_nxt;
    cand_idx_r  <= cand_idx_nxt;
    cand_dist_r <= cand_dist_nxt;
    out_acc_r   <= out_acc_nxt;
    out_ev_r    <= out_ev_nxt;
    out_idx_r   <= out_idx_nxt;
    out_dist_r  <= out_dist_nxt;
    out_new_r   <= out_new_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_entry_valid   = out_ev_r;
  assign out_entry_index   = out_idx_r;
  assign out_entry_dist    = out_dist_r;
  assign out_entry_was_new = out_new_r;
  assign out_last          = out_last_r;

endmodule

/* rtl/top_k_neighbor_list.sv */
// Sorted list of up to CAPACITY nearest neighbors, ascending by distance.
// An offer (in_cmd 0) scans the n stored words and, if it is accepted,
// moves each word behind the insert slot up and writes the new word there;
// a drain reads the n stored words, one result word per cycle after the
// first read. Both are paced by the single read port of the slot memory,
// which the sequencer walks one word per cycle through the shared compare
// unit. busy stays high while an item is in progress; each result word
// shows on out_* for exactly one cycle under out_valid and cannot be held
// off, so the receiver must take it then.
// An empty drain gives one word with out_entry_valid low and out_last high.
// cfg_keep_limit is always ready and must only be written while idle.
// depends on tkn_pkg, tkn_slot_ram and tkn_ctrl
module top_k_neighbor_list #(
  parameter int CAPACITY   = tkn_pkg::CAPACITY_DEF,
  parameter int INDEX_BITS = tkn_pkg::INDEX_BITS_DEF,
  parameter int DIST_BITS  = tkn_pkg::DIST_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_cmd,
  input  logic [INDEX_BITS-1:0]     in_candidate_index,
  input  logic [DIST_BITS-1:0]      in_candidate_dist,
  output logic                      out_valid,
  output logic                      out_accepted,
  output logic                      out_entry_valid,
  output logic [INDEX_BITS-1:0]     out_entry_index,
  output logic [DIST_BITS-1:0]      out_entry_dist,
  output logic                      out_entry_was_new,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tkn_pkg::KEEP_W-1:0] cfg_keep_limit
);
  import tkn_pkg::*;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WORD_W = 1 + INDEX_BITS + DIST_BITS;

  logic [KEEP_W-1:0] keep_r;
  logic [CNT_W-1:0]  limit;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      keep_r <= cfg_keep_limit;
    end
  end

  // zero means full capacity, larger values saturate
  always_comb begin
    if (keep_r == '0 || 32'(keep_r) > CAPACITY) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(keep_r);
    end
  end

  tkn_slot_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W),
    .WORD_W (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tkn_ctrl #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS),
    .DIST_BITS  (DIST_BITS),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W),
    .WORD_W     (WORD_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_candidate_index (in_candidate_index),
    .in_candidate_dist  (in_candidate_dist),
    .limit              (limit),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_entry_valid    (out_entry_valid),
    .out_entry_index    (out_entry_index),
    .out_entry_dist     (out_entry_dist),
    .out_entry_was_new  (out_entry_was_new),
    .out_last           (out_last),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data)
  );

endmodule

/* sim/tb_top_k_neighbor_list.sv */
`timescale 1ns / 100ps
// tb_top_k_neighbor_list: self-checking bench for the top-k neighbor list
// offers and drains are predicted word by word by a list model in a scoreboard class
// depends on tkn_pkg and top_k_neighbor_list
module tb_top_k_neighbor_list;
  import tkn_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int IW           = INDEX_BITS_DEF;
  localparam int DW           = DIST_BITS_DEF;
  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 2 * CAP + 8;
  localparam int PHASE_ITEMS  = 37;

  typedef struct packed {
    logic          accepted;
    logic          entry_valid;
    logic [IW-1:0] index;
    logic [DW-1:0] distance;
    logic          was_new;
    logic          last;
  } nbr_word_t;

  class nbr_scoreboard;
    logic [IW-1:0]     list_index [CAP];
    logic [DW-1:0]     list_dist [CAP];
    bit                list_new [CAP];
    int                list_fill;
    bit [KEEP_W-1:0]   keep_limit;
    nbr_word_t         expected_words [$];
    int                errors;

    function new();
      list_fill  = 0;
      keep_limit = '0;
      errors     = 0;
    endfunction

    function void set_keep_limit(bit [KEEP_W-1:0] v);
      keep_limit = v;
    endfunction

    function void queue_word(nbr_word_t w);
      expected_words.insert(expected_words.size(), w);
    endfunction

    function int active_limit();
      int lim;
      lim = (keep_limit == 0) ? CAP : int'(keep_limit);
      if (lim > CAP) lim = CAP;
      return lim;
    endfunction

    // sorted insert, returns 1 when the candidate goes in
    function bit try_insert(logic [IW-1:0] idx, logic [DW-1:0] dist_val);
      int pos;
      int i;
      int lim;
      lim = active_limit();
      pos = 0;
      for (i = 0; i < list_fill; i++) begin
        if (list_index[i] == idx || list_dist[i] == dist_val) return 1'b0;
        if (list_dist[i] < dist_val) pos = i + 1;
      end
      if (pos >= lim) return 1'b0;
      // farthest entry falls off when the array is full
      i = (list_fill < CAP) ? list_fill : CAP - 1;
      while (i > pos) begin
        list_index[i] = list_index[i-1];
        list_dist[i]  = list_dist[i-1];
        list_new[i]   = list_new[i-1];
        i--;
      end
      list_index[pos] = idx;
      list_dist[pos]  = dist_val;
      list_new[pos]   = 1'b1;
      list_fill       = (list_fill + 1 > lim) ? lim : list_fill + 1;
      return 1'b1;
    endfunction

    function void note_item(logic cmd, logic [IW-1:0] idx, logic [DW-1:0] dist_val);
      nbr_word_t w;
      int i;
      if (cmd == CMD_OFFER) begin
        w          = '0;
        w.accepted = try_insert(idx, dist_val);
        w.last     = 1'b1;
        queue_word(w);
      end else if (list_fill == 0) begin
        w      = '0;
        w.last = 1'b1;
        queue_word(w);
      end else begin
        for (i = 0; i < list_fill; i++) begin
          w             = '0;
          w.entry_valid = 1'b1;
          w.index       = list_index[i];
          w.distance    = list_dist[i];
          w.was_new     = list_new[i];
          w.last        = (i == list_fill - 1);
          queue_word(w);
          list_new[i] = 1'b0;
        end
      end
    endfunction

    function void compare_field(string name, logic [DW-1:0] exp_v, logic [DW-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(nbr_word_t act);
      nbr_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, expected none actual %h", $time, act);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      compare_field("accepted", DW'(exp_w.accepted), DW'(act.accepted));
      compare_field("entry_valid", DW'(exp_w.entry_valid), DW'(act.entry_valid));
      compare_field("entry_index", DW'(exp_w.index), DW'(act.index));
      compare_field("entry_dist", exp_w.distance, act.distance);
      compare_field("entry_was_new", DW'(exp_w.was_new), DW'(act.was_new));
      compare_field("last", DW'(exp_w.last), DW'(act.last));
    endfunction
  endclass

  logic               clk;
  logic               rst_n              = 1'b0;
  logic               start              = 1'b0;
  logic               busy;
  logic               in_cmd             = CMD_OFFER;
  logic [IW-1:0]      in_candidate_index = '0;
  logic [DW-1:0]      in_candidate_dist  = '0;
  logic               out_valid;
  logic               out_accepted;
  logic               out_entry_valid;
  logic [IW-1:0]      out_entry_index;
  logic [DW-1:0]      out_entry_dist;
  logic               out_entry_was_new;
  logic               out_last;
  logic               cfg_valid          = 1'b0;
  logic               cfg_ready;
  logic [KEEP_W-1:0]  cfg_keep_limit     = '0;

  nbr_scoreboard      sb = new();
  nbr_word_t          seen_word;
  int                 cycle_count = 0;

  top_k_neighbor_list uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_candidate_index (in_candidate_index),
    .in_candidate_dist  (in_candidate_dist),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_entry_valid    (out_entry_valid),
    .out_entry_index    (out_entry_index),
    .out_entry_dist     (out_entry_dist),
    .out_entry_was_new  (out_entry_was_new),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_keep_limit     (cfg_keep_limit)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // check result words first, then note the word accepted at this edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** top_k_neighbor_list: FAILED **");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        seen_word.accepted    = out_accepted;
        seen_word.entry_valid = out_entry_valid;
        seen_word.index       = out_entry_index;
        seen_word.distance    = out_entry_dist;
        seen_word.was_new     = out_entry_was_new;
        seen_word.last        = out_last;
        sb.check_word(seen_word);
      end
      if (start && !busy) sb.note_item(in_cmd, in_candidate_index, in_candidate_dist);
    end
  end

  task automatic send_item(logic cmd, logic [IW-1:0] idx, logic [DW-1:0] dist_val);
    start              <= 1'b1;
    in_cmd             <= cmd;
    in_candidate_index <= idx;
    in_candidate_dist  <= dist_val;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // one edge first so the word accepted last is noted and busy has risen
  task automatic wait_settled();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep_limit(logic [KEEP_W-1:0] v);
    cfg_valid      <= 1'b1;
    cfg_keep_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_keep_limit(v);
    cfg_valid <= 1'b0;
  endtask

  // mostly offers, some aimed at stored indexes or distances to hit the rejects
  task automatic random_item();
    logic [IW-1:0] idx;
    logic [DW-1:0] dist_val;
    idx      = IW'($urandom);
    dist_val = DW'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      send_item(CMD_DRAIN, idx, dist_val);
    end else begin
      if ($urandom_range(0, 3) == 0) dist_val = DW'($urandom_range(0, 63));
      if (sb.list_fill > 0 && $urandom_range(0, 5) == 0)
        idx = sb.list_index[$urandom_range(0, sb.list_fill - 1)];
      if (sb.list_fill > 0 && $urandom_range(0, 5) == 0)
        dist_val = sb.list_dist[$urandom_range(0, sb.list_fill - 1)];
      send_item(CMD_OFFER, idx, dist_val);
    end
  endtask

  initial begin
    bit [KEEP_W-1:0] phase_limits [6];
    int p;
    int n;
    phase_limits = '{5'd31, 5'd16, 5'd5, 5'd1, 5'd0, 5'd9};
    phase_limits[5] = KEEP_W'($urandom_range(2, CAP - 1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset limit
    send_item(CMD_DRAIN, '0, '0);
    send_item(CMD_OFFER, 16'h0000, 32'h0000_0000);
    send_item(CMD_OFFER, '1, '1);
    send_item(CMD_OFFER, 16'h0000, 32'h0000_0005);
    send_item(CMD_OFFER, 16'h0007, '1);
    send_item(CMD_OFFER, 16'h5555, 32'hAAAA_AAAA);
    send_item(CMD_OFFER, 16'hAAAA, 32'h5555_5555);
    send_item(CMD_DRAIN, '1, '1);
    send_item(CMD_DRAIN, '0, '0);

    // limit lowered below fill: the extra entries linger until the next insert
    wait_settled();
    write_keep_limit(5'd2);
    send_item(CMD_DRAIN, '0, '0);
    send_item(CMD_OFFER, 16'h0003, 32'h0000_0001);
    send_item(CMD_OFFER, 16'h0004, 32'h8000_0000);
    send_item(CMD_DRAIN, '0, '0);

    // list full at its limit: a closer candidate pushes the farthest one out
    wait_settled();
    write_keep_limit(5'd3);
    send_item(CMD_OFFER, 16'h0010, 32'h0000_0010);
    send_item(CMD_OFFER, 16'h0011, 32'h0000_0008);
    send_item(CMD_OFFER, 16'h0012, 32'h0000_0020);
    send_item(CMD_DRAIN, '0, '0);

    for (p = 0; p < 6; p++) begin
      wait_settled();
      write_keep_limit(phase_limits[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
        if (p == 2 && n == PHASE_ITEMS / 2) wait_settled();
        else if (p < 5 && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
      end
    end

    wait_settled();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("** top_k_neighbor_list: PASSED **");
    end else begin
      $display("** top_k_neighbor_list: FAILED **");
    end
    $finish;
  end

endmodule

/* top_k_neighbor_list.f */
rtl/tkn_pkg.sv
rtl/tkn_slot_ram.sv
rtl/tkn_ctrl.sv
rtl/top_k_neighbor_list.sv
sim/tb_top_k_neighbor_list.sv
